### sv/sliding_window_frame_rate_meter_macros.svh
// Assertion macros shared by the frame rate meter RTL.
`ifndef SLIDING_WINDOW_FRAME_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_FRAME_RATE_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swfrm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWFRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swfrm: next-cycle check failed");

`endif

### sv/swfrm_pkg.sv
`default_nettype none

package swfrm_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = $clog2(2 * WINDOW_DEPTH);
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);

    localparam int TS_W     = 48;
    localparam int FRAME_W  = 32;
    localparam int FPS_W    = 32;
    localparam int LIMIT_W  = 10;
    localparam int RATIO_W  = 5;
    localparam int NUM_W    = 34;
    localparam int DIV_W    = TS_W + 2;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    localparam logic [LIMIT_W-1:0] FPS_LIMIT_RESET = LIMIT_W'(60);
    localparam logic [FPS_W-1:0]   IDLE_FPS        = FPS_W'(60);
    localparam logic [NUM_W-1:0]   RATE_BASE       = NUM_W'(1000000);
    localparam logic [NUM_W-1:0]   SPAN_BASE       = NUM_W'(64'd1000000 * (WINDOW_DEPTH - 1));

    // fps_limit / 60 as a multiply by a reciprocal; exact over the 10-bit range.
    localparam int RATIO_RECIP = 1093;
    localparam int RATIO_SHIFT = 16;
    localparam int RATIO_PROD_W = 21;

    typedef struct packed {
        logic               operation;
        logic [TS_W-1:0]    timestamp_us;
        logic [FRAME_W-1:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic [FPS_W-1:0] current_fps;
        logic             recorded;
        logic             zero_interval;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_CHK,
        S_STORE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_DIV,
        S_SAT,
        S_OUT
    } t_state;

    function automatic logic [RATIO_W-1:0] ratio_of(input logic [LIMIT_W-1:0] limit);
        logic [RATIO_PROD_W-1:0] prod;
        prod = RATIO_PROD_W'(limit) * RATIO_PROD_W'(RATIO_RECIP);
        return prod[RATIO_SHIFT+RATIO_W-1:RATIO_SHIFT];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] s;
        if (idx >= IDX_W'(WINDOW_DEPTH)) begin
            s = idx - IDX_W'(WINDOW_DEPTH);
        end else begin
            s = idx;
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/sliding_window_frame_rate_meter.sv
// A query reads the ring and divides for the rate. Under frame gating a frame is first
// divided by the ratio from fps_limit and stored or skipped; with ratio zero it is stored at once.
// A zero interval skips the divide; a query with under two samples gives the idle rate.
// One item at a time: one restoring divider, 32 steps for gating and 50 for the rate, and the
// next input transfer is taken the cycle after the result is registered. Synchronous reset
// clears the sequencer, sample index and output valid, sets fps_limit to 60, keeps the ring.
`default_nettype none
`include "sliding_window_frame_rate_meter_macros.svh"

module sliding_window_frame_rate_meter
    import swfrm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LIMIT_W-1:0] r_fps_limit;
    logic               r_out_valid, n_out_valid;

    logic [TS_W-1:0]    r_ts, n_ts;
    logic               r_op, n_op;
    logic [RATIO_W-1:0] r_ratio, n_ratio;
    logic               r_rec, n_rec;
    logic               r_zero, n_zero;
    logic [FPS_W-1:0]   r_fps, n_fps;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [TS_W-1:0]    r_newest, n_newest;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_dq, n_dq;
    logic [DIV_W-1:0]   r_dvs, n_dvs;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_out_item          r_out_item, n_out_item;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [TS_W-1:0]    ram_rdata;

    logic [DIV_W:0]     step_sh;
    logic               step_ge;
    logic [DIV_W:0]     step_sub;
    logic [DIV_W-1:0]   step_rem;
    logic [DIV_W-1:0]   step_dq;
    logic [TS_W-1:0]    diff;
    logic [RATIO_W-1:0] ratio_eff;
    logic [NUM_W+RATIO_W-1:0] span_prod;

    swfrm_ram #(
        .WIDTH(TS_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_ts),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // One restoring division step, shared by frame gating and the rate quotient.
    always_comb begin
        step_sh  = {r_rem, r_dq[DIV_W-1]};
        step_sub = step_sh - {1'b0, r_dvs};
        step_ge  = (step_sh >= {1'b0, r_dvs});
        step_rem = step_ge ? step_sub[DIV_W-1:0] : step_sh[DIV_W-1:0];
        step_dq  = {r_dq[DIV_W-2:0], step_ge};
    end

    assign diff      = r_newest - ram_rdata;
    assign ratio_eff = (r_ratio == '0) ? RATIO_W'(1) : r_ratio;
    assign span_prod = (NUM_W + RATIO_W)'(SPAN_BASE) * (NUM_W + RATIO_W)'(ratio_eff);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_ts        = r_ts;
        n_op        = r_op;
        n_ratio     = r_ratio;
        n_rec       = r_rec;
        n_zero      = r_zero;
        n_fps       = r_fps;
        n_num       = r_num;
        n_newest    = r_newest;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_waddr   = slot_of(r_idx);
        ram_re      = 1'b0;
        ram_raddr   = slot_of(r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_item.operation;
                    n_ts    = i_in_item.timestamp_us;
                    n_ratio = ratio_of(r_fps_limit);
                    n_rec   = 1'b0;
                    n_zero  = 1'b0;
                    n_rem   = '0;
                    n_dq    = {i_in_item.frame_number, {(DIV_W - FRAME_W){1'b0}}};
                    n_dvs   = DIV_W'(ratio_of(r_fps_limit));
                    n_cnt   = CNT_W'(FRAME_W);
                    if (i_in_item.operation) begin
                        n_state = S_RD0;
                    end else if (ratio_of(r_fps_limit) == '0) begin
                        n_state = S_STORE;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_rem = step_rem;
                n_dq  = step_dq;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = (r_rem == '0) ? S_STORE : S_RD0;
            end
            S_STORE: begin
                ram_we = 1'b1;
                n_rec  = 1'b1;
                if (r_idx == IDX_W'(2 * WINDOW_DEPTH - 1)) begin
                    n_idx = IDX_W'(WINDOW_DEPTH);
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
                n_state = S_RD0;
            end
            S_RD0: begin
                if (r_idx < IDX_W'(2)) begin
                    n_fps   = IDLE_FPS;
                    n_state = S_OUT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(r_idx - IDX_W'(1));
                    if (r_idx < IDX_W'(WINDOW_DEPTH)) begin
                        n_num = RATE_BASE;
                    end else begin
                        n_num = span_prod[NUM_W-1:0];
                    end
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_newest = ram_rdata;
                ram_re   = 1'b1;
                if (r_idx < IDX_W'(WINDOW_DEPTH)) begin
                    ram_raddr = slot_of(r_idx - IDX_W'(2));
                end else begin
                    ram_raddr = slot_of(r_idx);
                end
                n_state = S_RD2;
            end
            S_RD2: begin
                if (diff == '0) begin
                    n_fps   = '1;
                    n_zero  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_rem   = '0;
                    n_dq    = DIV_W'({r_num, 1'b0}) + DIV_W'(diff);
                    n_dvs   = DIV_W'({diff, 1'b0});
                    n_cnt   = CNT_W'(DIV_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = step_rem;
                n_dq  = step_dq;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_fps   = (|r_dq[DIV_W-1:FPS_W]) ? '1 : r_dq[FPS_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_item.current_fps     = r_fps;
                    n_out_item.recorded        = r_rec;
                    n_out_item.zero_interval   = r_zero;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_fps_limit <= FPS_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fps_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts       <= n_ts;
        r_op       <= n_op;
        r_ratio    <= n_ratio;
        r_rec      <= n_rec;
        r_zero     <= n_zero;
        r_fps      <= n_fps;
        r_num      <= n_num;
        r_newest   <= n_newest;
        r_rem      <= n_rem;
        r_dq       <= n_dq;
        r_dvs      <= n_dvs;
        r_cnt      <= n_cnt;
        r_out_item <= n_out_item;
    end

    `SWFRM_ASSERT_NXT(a_accept_starts_work, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_state != S_IDLE)
    `SWFRM_ASSERT_IMP(a_div_count_live, i_clk, i_rst_n,
        r_state == S_DIV || r_state == S_MOD, r_cnt != '0)
    `SWFRM_ASSERT_NXT(a_store_moves_index, i_clk, i_rst_n,
        r_state == S_STORE, r_idx != $past(r_idx))
    `SWFRM_ASSERT_IMP(a_zero_saturates, i_clk, i_rst_n,
        o_out_valid && o_out_item.zero_interval, o_out_item.current_fps == '1)
    `SWFRM_ASSERT_IMP(a_query_not_stored, i_clk, i_rst_n, r_state == S_STORE, !r_op)

endmodule

`default_nettype wire

### sv/swfrm_ram.sv
`default_nettype none

module swfrm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
